// ===== src/assert_macros.svh =====
// Assertion macros shared by the line cell rasteriser.
// Expect clk and rst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LCR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset
`define LCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/lcr_pkg.sv =====
// Types and constants for the line cell rasteriser.
// No dependencies; used by every module of the block.
package lcr_pkg;

    localparam int COORD_W      = 6;
    localparam int GRID_SIZE_DEF = 64;
    localparam int ERR_W        = COORD_W + 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_W-1:0] coord_t;

    // One classified line, ready to trace
    typedef struct packed {
        coord_t a0;
        coord_t a1;
        coord_t b0;
        coord_t d_major;
        coord_t d_minor;
        logic   b_down;
        logic   steep;
        logic   skip_first;
    } line_cmd_t;

    typedef struct packed {
        logic busy;
        logic in_span;
    } back_status_t;

endpackage

// ===== src/lcr_front.sv =====
// Front end: clamps the endpoints, picks the major axis, orders the ends.
// Depends on lcr_pkg.
module lcr_front #(
    parameter int GRID_SIZE = lcr_pkg::GRID_SIZE_DEF
) (
    input  lcr_pkg::coord_t    start_x,
    input  lcr_pkg::coord_t    start_y,
    input  lcr_pkg::coord_t    end_x,
    input  lcr_pkg::coord_t    end_y,
    output lcr_pkg::line_cmd_t cmd,
    output logic               has_cells
);

    localparam lcr_pkg::coord_t MAX_COORD = lcr_pkg::COORD_W'(GRID_SIZE - 1);

    lcr_pkg::coord_t sx, sy, ex, ey;
    lcr_pkg::coord_t adx, ady;
    lcr_pkg::coord_t a0r, a1r, b0r, b1r;
    lcr_pkg::coord_t a0, a1, b0, b1;
    logic            steep, swap;

    function automatic lcr_pkg::coord_t clamp(input lcr_pkg::coord_t v);
        clamp = (v > MAX_COORD) ? MAX_COORD : v;
    endfunction

    function automatic lcr_pkg::coord_t absdiff(input lcr_pkg::coord_t p,
                                                input lcr_pkg::coord_t q);
        absdiff = (p > q) ? (p - q) : (q - p);
    endfunction

    always_comb
    begin
        sx  = clamp(start_x);
        sy  = clamp(start_y);
        ex  = clamp(end_x);
        ey  = clamp(end_y);
        adx = absdiff(sx, ex);
        ady = absdiff(sy, ey);
        steep = ady > adx;
        a0r = steep ? sy : sx;
        b0r = steep ? sx : sy;
        a1r = steep ? ey : ex;
        b1r = steep ? ex : ey;
        // trace toward the increasing major coordinate
        swap = a0r > a1r;
        a0 = swap ? a1r : a0r;
        a1 = swap ? a0r : a1r;
        b0 = swap ? b1r : b0r;
        b1 = swap ? b0r : b1r;
        cmd.a0         = a0;
        cmd.a1         = a1;
        cmd.b0         = b0;
        cmd.d_major    = a1 - a0;
        cmd.d_minor    = absdiff(b0, b1);
        cmd.b_down     = b0 > b1;
        cmd.steep      = steep;
        // the given end cell sits first in the trace when swapped, else last
        cmd.skip_first = swap;
        has_cells      = (a1 != a0);
    end

endmodule

// ===== src/lcr_queue.sv =====
// Short command queue between the front and back ends.
// Depends on lcr_pkg.
module lcr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lcr_pkg::line_cmd_t push_cmd,
    input  logic               pop,
    output lcr_pkg::line_cmd_t head,
    output logic               not_empty,
    output logic               full,
    output logic [lcr_pkg::QCNT_W-1:0] count
);

    lcr_pkg::line_cmd_t                mem [lcr_pkg::QUEUE_DEPTH];
    logic [lcr_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [lcr_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [lcr_pkg::QCNT_W-1:0]        count_reg, count_next;

    localparam logic [lcr_pkg::QCNT_W-1:0] DEPTH_CNT = lcr_pkg::QCNT_W'(lcr_pkg::QUEUE_DEPTH);
    localparam logic [lcr_pkg::QPTR_W-1:0] LAST_PTR  = lcr_pkg::QPTR_W'(lcr_pkg::QUEUE_DEPTH - 1);

    assign not_empty = count_reg != '0;
    assign full      = count_reg == DEPTH_CNT;
    assign head      = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/lcr_back.sv =====
// Back end: steps one line a cell per cycle into an output register while the output is not stalled.
// Depends on lcr_pkg.
module lcr_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcr_pkg::line_cmd_t     head,
    input  logic                   not_empty,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output lcr_pkg::coord_t        cell_x,
    output lcr_pkg::coord_t        cell_y,
    output logic                   last_cell,
    output lcr_pkg::back_status_t  status
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                         state_reg, state_next;
    lcr_pkg::line_cmd_t             cmd_reg;
    lcr_pkg::coord_t                a_reg, b_reg;
    logic signed [lcr_pkg::ERR_W-1:0] err_reg, err_next, err_add;
    logic                           first_reg;
    logic                           out_valid_reg, out_valid_next;
    lcr_pkg::coord_t                cell_x_reg, cell_y_reg;
    logic                           last_reg;
    logic                           out_free, emit, at_last, advance, move;
    lcr_pkg::coord_t                a_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign a_last   = cmd_reg.skip_first ? cmd_reg.a1 : cmd_reg.a1 - 1'b1;
    assign at_last  = a_reg == a_last;
    assign emit     = !(first_reg && cmd_reg.skip_first);
    assign advance  = (state_reg == ST_RUN) && out_free;
    assign pop      = (state_reg == ST_IDLE) && not_empty;
    assign err_add  = err_reg + $signed({2'b00, cmd_reg.d_minor});
    assign move     = $signed({err_add, 1'b0}) >= $signed({3'b000, cmd_reg.d_major});
    assign err_next = move ? err_add - $signed({2'b00, cmd_reg.d_major}) : err_add;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (not_empty)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (advance && emit)
                begin
                    out_valid_next = 1'b1;
                    if (at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg   <= head;
            a_reg     <= head.a0;
            b_reg     <= head.b0;
            err_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (advance)
        begin
            a_reg     <= a_reg + 1'b1;
            err_reg   <= err_next;
            first_reg <= 1'b0;
            if (move)
            begin
                b_reg <= cmd_reg.b_down ? b_reg - 1'b1 : b_reg + 1'b1;
            end
        end
        // emit the cell held before this step's minor move
        if (advance && emit)
        begin
            cell_x_reg <= cmd_reg.steep ? b_reg : a_reg;
            cell_y_reg <= cmd_reg.steep ? a_reg : b_reg;
            last_reg   <= at_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cell_x         = cell_x_reg;
    assign cell_y         = cell_y_reg;
    assign last_cell      = last_reg;
    assign status.busy    = state_reg == ST_RUN;
    assign status.in_span = a_reg <= cmd_reg.a1;

endmodule

// ===== src/line_cell_rasterizer.sv =====
// An accepted line is written to the queue; the back end pops it when idle, and its
// cells are registered at the output (a leading given end cell is stepped over unemitted).
// Throughput: one cell per cycle while the output is not stalled; new lines are accepted
// while the back end traces, until the queue is full.
// Lines with start equal to end give no cell; two lines may queue.
// Reset: rst_n clears the queue, the stepping state and the output valid at once.
`include "assert_macros.svh"

module line_cell_rasterizer #(
    parameter int GRID_SIZE = lcr_pkg::GRID_SIZE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  lcr_pkg::coord_t start_x,
    input  lcr_pkg::coord_t start_y,
    input  lcr_pkg::coord_t end_x,
    input  lcr_pkg::coord_t end_y,
    output logic            out_valid,
    input  logic            out_stall,
    output lcr_pkg::coord_t cell_x,
    output lcr_pkg::coord_t cell_y,
    output logic            last_cell
);

    lcr_pkg::line_cmd_t            front_cmd, head;
    lcr_pkg::back_status_t         status;
    logic                          has_cells, push, pop, not_empty, full;
    logic [lcr_pkg::QCNT_W-1:0]    q_count;

    lcr_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .cmd       (front_cmd),
        .has_cells (has_cells)
    );

    // drop lines with no cells to trace
    assign in_stall = full;
    assign push     = in_valid && !full && has_cells;

    lcr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full),
        .count     (q_count)
    );

    lcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .last_cell (last_cell),
        .status    (status)
    );

    `LCR_ASSERT_IMPL(a_queue_bound, 1'b1, q_count <= lcr_pkg::QCNT_W'(lcr_pkg::QUEUE_DEPTH))
    `LCR_ASSERT_IMPL(a_trace_in_span, status.busy, status.in_span)
    `LCR_ASSERT_IMPL(a_line_open, out_valid && !last_cell, status.busy)
    `LCR_ASSERT_NEXT(a_no_spurious, !status.busy && !not_empty && !out_valid, !out_valid)

endmodule

// ===== tb/lcr_cell_checker.sv =====
// Cell checker for the line cell rasteriser: traces each accepted line request
// and compares every emitted cell in order. Depends on lcr_pkg for coord_t.
module lcr_cell_checker #(
    parameter int GRID_SIZE = lcr_pkg::GRID_SIZE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_stall,
    input  lcr_pkg::coord_t start_x,
    input  lcr_pkg::coord_t start_y,
    input  lcr_pkg::coord_t end_x,
    input  lcr_pkg::coord_t end_y,
    input  logic            out_valid,
    input  logic            out_stall,
    input  lcr_pkg::coord_t cell_x,
    input  lcr_pkg::coord_t cell_y,
    input  logic            last_cell,
    output int              errors,
    output int              pending
);

    typedef struct packed {
        lcr_pkg::coord_t x;
        lcr_pkg::coord_t y;
        logic            last;
    } cell_t;

    localparam int MAX_CELLS = 64;

    cell_t expected_cells[$];
    int    error_count = 0;

    assign errors  = error_count;
    assign pending = expected_cells.size();

    function automatic int grid_clamp(input lcr_pkg::coord_t v);
        int c;
        c = int'(v);
        if (c > GRID_SIZE - 1)
            c = GRID_SIZE - 1;
        return c;
    endfunction

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Queue the cells of one Bresenham line, end cell left out
    function automatic void trace_line_cells(input lcr_pkg::coord_t sx_in,
                                             input lcr_pkg::coord_t sy_in,
                                             input lcr_pkg::coord_t ex_in,
                                             input lcr_pkg::coord_t ey_in);
        int    sx, sy, ex, ey;
        int    a0, a1, b0, b1, t;
        int    d_major, d_minor, bstep, err, b, cx, cy, cnt;
        bit    steep, have_prev;
        cell_t prev, c;
        sx = grid_clamp(sx_in);
        sy = grid_clamp(sy_in);
        ex = grid_clamp(ex_in);
        ey = grid_clamp(ey_in);
        steep = mag(ey - sy) > mag(ex - sx);
        a0 = steep ? sy : sx;
        b0 = steep ? sx : sy;
        a1 = steep ? ey : ex;
        b1 = steep ? ex : ey;
        if (a0 > a1)
        begin
            t = a0; a0 = a1; a1 = t;
            t = b0; b0 = b1; b1 = t;
        end
        d_major   = a1 - a0;
        d_minor   = mag(b1 - b0);
        bstep     = (b0 < b1) ? 1 : -1;
        err       = 0;
        b         = b0;
        cnt       = 0;
        have_prev = 1'b0;
        prev      = '0;
        for (int a = a0; a <= a1; a++)
        begin
            cx = steep ? b : a;
            cy = steep ? a : b;
            err += d_minor;
            // the emitted cell is the one held before the minor move
            if (2 * err >= d_major)
            begin
                b   += bstep;
                err -= d_major;
            end
            if (cx == ex && cy == ey)
                continue;
            if (cnt >= MAX_CELLS)
                break;
            c.x  = lcr_pkg::coord_t'(cx);
            c.y  = lcr_pkg::coord_t'(cy);
            c.last = 1'b0;
            if (have_prev)
                expected_cells.insert(expected_cells.size(), prev);
            prev      = c;
            have_prev = 1'b1;
            cnt++;
        end
        if (have_prev)
        begin
            prev.last = 1'b1;
            expected_cells.insert(expected_cells.size(), prev);
        end
    endfunction

    always @(posedge clk)
    begin
        cell_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                trace_line_cells(start_x, start_y, end_x, end_y);
            if (out_valid && !out_stall)
            begin
                if (expected_cells.size() == 0)
                begin
                    $display("%0t: unexpected cell: expected none, got x=%0d y=%0d last=%0b",
                             $time, cell_x, cell_y, last_cell);
                    error_count++;
                end
                else
                begin
                    want = expected_cells.pop_front();
                    if (cell_x !== want.x || cell_y !== want.y || last_cell !== want.last)
                    begin
                        $display({"%0t: cell mismatch: expected x=%0d y=%0d last=%0b,",
                                  " got x=%0d y=%0d last=%0b"},
                                 $time, want.x, want.y, want.last,
                                 cell_x, cell_y, last_cell);
                        error_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_line_cell_rasterizer.sv =====
// Top of the line cell rasteriser testbench: drives line requests and the
// output stall, instantiates the block and lcr_cell_checker, gives the verdict.
module tb_line_cell_rasterizer;

    localparam int COORD_MAX  = lcr_pkg::GRID_SIZE_DEF - 1;
    localparam int RAND_LINES = 260;
    localparam int CALM_TAIL  = 40;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 80;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    lcr_pkg::coord_t start_x;
    lcr_pkg::coord_t start_y;
    lcr_pkg::coord_t end_x;
    lcr_pkg::coord_t end_y;
    logic            out_valid;
    logic            out_stall;
    lcr_pkg::coord_t cell_x;
    lcr_pkg::coord_t cell_y;
    logic            last_cell;

    int errors;
    int pending;
    bit calm;
    int idle_cycles;

    line_cell_rasterizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .last_cell (last_cell)
    );

    lcr_cell_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .last_cell (last_cell),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int clip_coord(input int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // Present one line request from a falling edge, after an optional random idle gap, and hold it until taken
    task automatic send_line(input int sx, input int sy, input int ex, input int ey);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= lcr_pkg::coord_t'(sx);
        start_y  <= lcr_pkg::coord_t'(sy);
        end_x    <= lcr_pkg::coord_t'(ex);
        end_y    <= lcr_pkg::coord_t'(ey);
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Output stall in random bursts, released between them and never started while calm
    initial
    begin
        int burst;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 17);
                out_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles in which neither a request nor a cell moves; fail at IDLE_LIMIT
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("line_cell_rasterizer: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int i, kind, sx, sy, ex, ey;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        start_x  = '0;
        start_y  = '0;
        end_x    = '0;
        end_y    = '0;
        calm     = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: grid corners, short and mid-grid lines, both directions, steep and shallow, degenerate
        send_line(0, 0, COORD_MAX, COORD_MAX);
        send_line(COORD_MAX, COORD_MAX, 0, 0);
        send_line(0, 0, COORD_MAX, 0);
        send_line(COORD_MAX, 0, 0, 0);
        send_line(0, 0, 0, COORD_MAX);
        send_line(0, COORD_MAX, 0, 0);
        send_line(0, COORD_MAX, COORD_MAX, 0);
        send_line(COORD_MAX, 0, 0, COORD_MAX);
        send_line(5, 5, 5, 5);
        send_line(0, 0, 0, 0);
        send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_line(0, 0, 1, 0);
        send_line(1, 0, 0, 0);
        send_line(30, 30, 31, 31);
        send_line(10, 10, 20, 13);
        send_line(20, 13, 10, 10);
        send_line(10, 10, 13, 40);
        send_line(13, 40, 10, 10);
        send_line(7, 3, 12, 8);
        send_line(30, 30, 31, 32);
        send_line(0, 0, COORD_MAX, COORD_MAX - 1);
        send_line(COORD_MAX - 1, COORD_MAX, 0, 0);

        for (i = 0; i < RAND_LINES; i++)
        begin
            // alternate idling stretches with calm ones; keep the tail calm
            calm = (i >= RAND_LINES - CALM_TAIL) || ((i / 40) % 3 == 2);
            kind = $urandom_range(0, 7);
            sx   = $urandom_range(0, COORD_MAX);
            sy   = $urandom_range(0, COORD_MAX);
            if (kind == 0)
            begin
                ex = sx;
                ey = sy;
            end
            else if (kind <= 3)
            begin
                ex = clip_coord(sx + $urandom_range(0, 8) - 4);
                ey = clip_coord(sy + $urandom_range(0, 8) - 4);
            end
            else
            begin
                ex = $urandom_range(0, COORD_MAX);
                ey = $urandom_range(0, COORD_MAX);
            end
            send_line(sx, sy, ex, ey);
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("line_cell_rasterizer: match");
        else
            $display("line_cell_rasterizer: mismatch");
        $finish;
    end

endmodule
